FILE: rtl/programmable_crc_engine_assert.svh
// ----------------------------------------------------------------------------
// programmable_crc_engine_assert.svh
// Assertion macros shared by the CRC engine RTL.
// ----------------------------------------------------------------------------
`ifndef PROGRAMMABLE_CRC_ENGINE_ASSERT_SVH
`define PROGRAMMABLE_CRC_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrc_pkg
// Types, register map and bit-manipulation helpers for the CRC engine.
// ----------------------------------------------------------------------------
package pcrc_pkg;

    localparam int unsigned ADDR_W = 5;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_POLY      = 3'd0,
        REG_SEED      = 3'd1,
        REG_WIDTH     = 3'd2,
        REG_IN_XPOSE  = 3'd3,
        REG_OUT_XPOSE = 3'd4,
        REG_INVERT    = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        IN_NONE       = 2'd0,
        IN_BITS       = 2'd1,
        IN_BITS_BYTES = 2'd2,
        IN_BYTES      = 2'd3
    } in_xpose_t;

    typedef enum logic [1:0] {
        OUT_NONE  = 2'd0,
        OUT_BITS  = 2'd1,
        OUT_FULL  = 2'd2,
        OUT_BYTES = 2'd3
    } out_xpose_t;

    localparam logic [31:0] POLY_RESET = 32'h0000_1021;
    localparam logic [31:0] SEED_RESET = 32'hFFFF_FFFF;
    localparam logic [31:0] MASK_16    = 32'h0000_FFFF;
    localparam logic [2:0]  MAX_BYTES  = 3'd4;

    function automatic logic [7:0] rev_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[k] = b[7 - k];
        end
        return r;
    endfunction

    function automatic logic [31:0] rev_in_bytes(input logic [31:0] v);
        logic [31:0] r;
        for (int j = 0; j < 4; j++)
        begin
            r[8*j +: 8] = rev_byte(v[8*j +: 8]);
        end
        return r;
    endfunction

    function automatic logic [31:0] rev_word(input logic [31:0] v);
        logic [31:0] r;
        for (int k = 0; k < 32; k++)
        begin
            r[k] = v[31 - k];
        end
        return r;
    endfunction

    // One byte through the LFSR, MSB first. poly must already be masked.
    function automatic logic [31:0] crc_byte_step(
        input logic [31:0] crc,
        input logic [7:0]  b,
        input logic [31:0] poly,
        input logic        w32
    );
        logic [31:0] c;
        logic        msb;
        c = crc;
        if (w32)
        begin
            c[31:24] = c[31:24] ^ b;
        end
        else
        begin
            c[15:8] = c[15:8] ^ b;
        end
        for (int k = 0; k < 8; k++)
        begin
            msb = w32 ? c[31] : c[15];
            c   = {c[30:0], 1'b0} ^ (msb ? poly : 32'h0);
        end
        // bits shifted above bit 15 never feed back, so masking once is enough
        return w32 ? c : (c & MASK_16);
    endfunction

endpackage

FILE: rtl/programmable_crc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// programmable_crc_engine
// Programmable 16/32-bit CRC unit with input/output transposition.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries one word per handshake:
//   data_word holds up to four bytes, first byte in bits 31:24; byte_count
//   says how many leading bytes count (values above four act as four, zero
//   feeds no bytes); first reloads the seed before the bytes are folded in.
//   Output channel (result_valid / result_stall) returns one checksum word
//   per input word, in order.
//   The word passes the input register, then the result register, before
//   result_valid rises. Throughput: one word per cycle while result_stall
//   is low; the CRC register feedback through four unrolled byte steps sets
//   this.
//   When result_stall holds the result register, the input register still
//   takes one word; item_stall rises only once both stages are full.
//   Reset clears the CRC register to zero, empties both stages and loads
//   the register defaults (CRC-16 CCITT polynomial, all-ones seed).
//   Configuration goes through the APB port and must be written only
//   while no word is in flight.
// ----------------------------------------------------------------------------
`include "programmable_crc_engine_assert.svh"

module programmable_crc_engine (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input word channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        first,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] checksum
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]           poly_reg;
    logic [31:0]           seed_reg;
    logic                  width32_reg;
    pcrc_pkg::in_xpose_t   in_xpose_reg;
    pcrc_pkg::out_xpose_t  out_xpose_reg;
    logic                  invert_reg;
    logic                  cfg_write;
    logic [2:0]            cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= pcrc_pkg::POLY_RESET;
            seed_reg      <= pcrc_pkg::SEED_RESET;
            width32_reg   <= 1'b0;
            in_xpose_reg  <= pcrc_pkg::IN_NONE;
            out_xpose_reg <= pcrc_pkg::OUT_NONE;
            invert_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                pcrc_pkg::REG_POLY:      poly_reg      <= pwdata;
                pcrc_pkg::REG_SEED:      seed_reg      <= pwdata;
                pcrc_pkg::REG_WIDTH:     width32_reg   <= pwdata[0];
                pcrc_pkg::REG_IN_XPOSE:  in_xpose_reg  <= pcrc_pkg::in_xpose_t'(pwdata[1:0]);
                pcrc_pkg::REG_OUT_XPOSE: out_xpose_reg <= pcrc_pkg::out_xpose_t'(pwdata[1:0]);
                pcrc_pkg::REG_INVERT:    invert_reg    <= pwdata[0];
                default:                 ;   // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            pcrc_pkg::REG_POLY:      prdata = poly_reg;
            pcrc_pkg::REG_SEED:      prdata = seed_reg;
            pcrc_pkg::REG_WIDTH:     prdata = {31'h0, width32_reg};
            pcrc_pkg::REG_IN_XPOSE:  prdata = {30'h0, in_xpose_reg};
            pcrc_pkg::REG_OUT_XPOSE: prdata = {30'h0, out_xpose_reg};
            pcrc_pkg::REG_INVERT:    prdata = {31'h0, invert_reg};
            default:                 prdata = 32'h0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register -> CRC logic -> result register
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic [31:0] s1_data_reg;
    logic [2:0]  s1_count_reg;
    logic        s1_first_reg;
    logic        out_valid_reg;
    logic [31:0] out_sum_reg;
    logic [31:0] out_sum_next;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        advance;   // result register free to load
    logic        s1_load;   // input register free to load
    logic        s1_move;   // stage-1 word folds into CRC this cycle

    assign advance    = !out_valid_reg || !result_stall;
    assign s1_load    = advance || !s1_valid_reg;
    assign s1_move    = s1_valid_reg && advance;
    assign item_stall = !s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= 32'h0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && item_valid)
        begin
            s1_data_reg  <= data_word;
            s1_count_reg <= byte_count;
            s1_first_reg <= first;
        end
        if (s1_move)
        begin
            out_sum_reg <= out_sum_next;
        end
    end

    // ------------------------------------------------------------------
    // CRC datapath: four unrolled byte steps
    // ------------------------------------------------------------------
    logic [31:0]      mask;
    logic [31:0]      poly_m;
    logic [2:0]       n_bytes;
    logic [3:0][7:0]  data_bytes;
    logic             swap_order;
    logic             flip_bits;
    logic [31:0]      crc_run;
    logic [2:0]       idx_wide;
    logic [1:0]       idx;
    logic [7:0]       cur_byte;
    logic [31:0]      xposed;

    assign mask       = width32_reg ? 32'hFFFF_FFFF : pcrc_pkg::MASK_16;
    assign poly_m     = poly_reg & mask;
    assign n_bytes    = (s1_count_reg > pcrc_pkg::MAX_BYTES) ? pcrc_pkg::MAX_BYTES
                                                            : s1_count_reg;
    assign swap_order = (in_xpose_reg == pcrc_pkg::IN_BITS_BYTES) ||
                        (in_xpose_reg == pcrc_pkg::IN_BYTES);
    assign flip_bits  = (in_xpose_reg == pcrc_pkg::IN_BITS) ||
                        (in_xpose_reg == pcrc_pkg::IN_BITS_BYTES);

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            data_bytes[j] = s1_data_reg[31 - 8*j -: 8];
        end
    end

    always_comb
    begin
        crc_run  = (s1_first_reg ? seed_reg : crc_reg) & mask;
        idx_wide = 3'd0;
        idx      = 2'd0;
        cur_byte = 8'h0;
        for (int i = 0; i < 4; i++)
        begin
            // byte order is reversed across the taken bytes only
            idx_wide = swap_order ? (n_bytes - 3'd1 - 3'(i)) : 3'(i);
            idx      = idx_wide[1:0];
            cur_byte = flip_bits ? pcrc_pkg::rev_byte(data_bytes[idx]) : data_bytes[idx];
            if (3'(i) < n_bytes)
            begin
                crc_run = pcrc_pkg::crc_byte_step(crc_run, cur_byte, poly_m, width32_reg);
            end
        end
        crc_next = crc_run;
    end

    // Read-side transposition acts within the active width.
    always_comb
    begin
        case (out_xpose_reg)
            pcrc_pkg::OUT_BITS:  xposed = pcrc_pkg::rev_in_bytes(crc_next);
            pcrc_pkg::OUT_FULL:  xposed = width32_reg ? pcrc_pkg::rev_word(crc_next)
                                                      : (pcrc_pkg::rev_word(crc_next) >> 16);
            pcrc_pkg::OUT_BYTES: xposed = width32_reg
                                   ? {crc_next[7:0], crc_next[15:8],
                                      crc_next[23:16], crc_next[31:24]}
                                   : {16'h0, crc_next[7:0], crc_next[15:8]};
            default:             xposed = crc_next;
        endcase
        out_sum_next = (invert_reg ? ~xposed : xposed) & mask;
    end

    assign result_valid = out_valid_reg;
    assign checksum     = out_sum_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PCRC_ASSERT_SAME(a_stall_only_when_full, item_stall, s1_valid_reg && out_valid_reg,
        "input stalled while a stage is empty")
    `PCRC_ASSERT_NEXT(a_move_gives_result, s1_move, result_valid && $stable(width32_reg),
        "folded word did not reach the result register")
    `PCRC_ASSERT_NEXT(a_crc_holds, !s1_move, $stable(crc_reg),
        "CRC register changed without a word")
    `PCRC_ASSERT_SAME(a_upper_zero_16, result_valid && !width32_reg, checksum[31:16] == 16'h0,
        "16-bit result has upper bits set")

endmodule
